// ----- src/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers; compiled out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// clocked check, masked while reset is asserted
`define AST_ON_RST(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("%m: check failed");

// clocked check, active in and out of reset
`define AST_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) else $error("%m: check failed");

`else

`define AST_ON_RST(lbl, clk, rst_n, prop)
`define AST_ALWAYS(lbl, clk, prop)

`endif

`endif

// ----- src/atps_pkg.sv -----
// ----------------------------------------------------------------------------
// atps_pkg
// Shared types and constants of the angle tracking PLL speed estimator.
// ----------------------------------------------------------------------------
package atps_pkg;

    // phase resolution used by the sine evaluation
    localparam int ANGLE_BITS = 16;
    localparam logic [31:0] PHASE_KEEP = ~((32'd1 << (32 - ANGLE_BITS)) - 32'd1);
    localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;

    // polynomial sin(pi/2 x) = x(A - x^2(B - C x^2)), Q1.16
    localparam logic [16:0] SIN_A = 17'd102944;
    localparam logic [16:0] SIN_B = 17'd42047;
    localparam logic [17:0] SIN_C = 18'd4640;

    // shared multiplier widths
    localparam int MUL_A_W = 34;
    localparam int MUL_B_W = 18;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    // configuration port
    localparam int APB_AW = 4;
    localparam int APB_DW = 32;

    localparam logic [15:0] PROP_GAIN_RST    = 16'd1200;
    localparam logic [31:0] INTEG_GAIN_RST   = 32'd301989888;
    localparam logic [31:0] STEP_GAIN_RST    = 32'd34178;
    localparam logic [15:0] FILTER_ALPHA_RST = 16'd328;

    typedef enum logic [1:0] {
        REG_PROP_GAIN,
        REG_INTEG_GAIN,
        REG_STEP_GAIN,
        REG_FILTER_ALPHA
    } t_reg_idx;

    typedef struct packed {
        logic [15:0] prop_gain;
        logic [31:0] integ_gain;
        logic [31:0] step_gain;
        logic [15:0] filter_alpha;
    } t_cfg;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD,
        ST_SIN1,
        ST_SIN2,
        ST_SIN3,
        ST_SIN4,
        ST_ERR0,
        ST_ERR1,
        ST_ERR2,
        ST_SPD0,
        ST_SPD1,
        ST_SPD2,
        ST_ADV0,
        ST_ADV1,
        ST_FILT
    } t_state;

endpackage

// ----- src/atps_if.sv -----
// ----------------------------------------------------------------------------
// atps_if
// Valid/ready channels for angle samples and speed results.
// ----------------------------------------------------------------------------
interface atps_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] angle_in;

    modport source (output valid, output angle_in, input ready);
    modport sink   (input valid, input angle_in, output ready);
endinterface

interface atps_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] speed_filtered;
    logic signed [31:0] speed_raw;
    logic        [15:0] tracked_angle;

    modport source (output valid, output speed_filtered, output speed_raw,
                    output tracked_angle, input ready);
    modport sink   (input valid, input speed_filtered, input speed_raw,
                    input tracked_angle, output ready);
endinterface

// ----- src/atps_mul.sv -----
// ----------------------------------------------------------------------------
// atps_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module atps_mul (
    input  logic                                 i_clk,
    input  logic signed [atps_pkg::MUL_A_W-1:0] i_a,
    input  logic signed [atps_pkg::MUL_B_W-1:0] i_b,
    output logic signed [atps_pkg::MUL_P_W-1:0] o_p
);

    logic signed [atps_pkg::MUL_P_W-1:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= i_a * i_b;
    end

    assign o_p = r_p;

endmodule

// ----- src/atps_cfg.sv -----
// ----------------------------------------------------------------------------
// atps_cfg
// APB register file holding the loop gains and filter coefficient.
// ----------------------------------------------------------------------------
module atps_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [atps_pkg::APB_AW-1:0]   paddr,
    input  logic [atps_pkg::APB_DW-1:0]   pwdata,
    output logic [atps_pkg::APB_DW-1:0]   prdata,
    output logic                          pready,
    output atps_pkg::t_cfg                o_cfg
);

    atps_pkg::t_cfg    r_cfg;
    atps_pkg::t_reg_idx w_idx;
    logic              w_wr;

    assign w_idx = atps_pkg::t_reg_idx'(paddr[3:2]);
    assign w_wr  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.prop_gain    <= atps_pkg::PROP_GAIN_RST;
            r_cfg.integ_gain   <= atps_pkg::INTEG_GAIN_RST;
            r_cfg.step_gain    <= atps_pkg::STEP_GAIN_RST;
            r_cfg.filter_alpha <= atps_pkg::FILTER_ALPHA_RST;
        end else if (w_wr) begin
            case (w_idx)
                atps_pkg::REG_PROP_GAIN:    r_cfg.prop_gain    <= pwdata[15:0];
                atps_pkg::REG_INTEG_GAIN:   r_cfg.integ_gain   <= pwdata;
                atps_pkg::REG_STEP_GAIN:    r_cfg.step_gain    <= pwdata;
                atps_pkg::REG_FILTER_ALPHA: r_cfg.filter_alpha <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            atps_pkg::REG_PROP_GAIN:    prdata = {16'd0, r_cfg.prop_gain};
            atps_pkg::REG_INTEG_GAIN:   prdata = r_cfg.integ_gain;
            atps_pkg::REG_STEP_GAIN:    prdata = r_cfg.step_gain;
            atps_pkg::REG_FILTER_ALPHA: prdata = {16'd0, r_cfg.filter_alpha};
            default:                    prdata = '0;
        endcase
    end

    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

endmodule

// ----- src/angle_tracking_pll_speed.sv -----
// ----------------------------------------------------------------------------
// angle_tracking_pll_speed
// Angle tracking PLL: phase error, PI speed, phase advance, speed low-pass.
// ----------------------------------------------------------------------------
// One angle sample is taken when the block is idle; its result is loaded into
// the output register in the last step, ST_FILT, and the block then returns to
// idle, so a new sample is taken only once the last one has reached the output.
// The pace is set by a single 34x18 multiplier that does all 24 products in
// sequence: four polynomial sines of four products each, two for the phase
// error, one proportional, two partial products each for the integral term and
// the phase advance, and one for the filter. A result not yet taken holds the
// block in its last step. Gains live in four APB registers at 0x0, 0x4, 0x8
// and 0xC; write them only while no sample is in flight.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module angle_tracking_pll_speed (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    atps_in_if.sink                     i_in,
    atps_out_if.source                  o_out,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [atps_pkg::APB_AW-1:0] paddr,
    input  logic [atps_pkg::APB_DW-1:0] pwdata,
    output logic [atps_pkg::APB_DW-1:0] prdata,
    output logic                        pready
);

    atps_pkg::t_cfg   w_cfg;
    atps_pkg::t_state r_state, n_state;

    logic [1:0]        r_idx, n_idx;
    logic [15:0]       r_angle, n_angle;
    logic [31:0]       r_track, n_track;
    logic [31:0]       r_esum, n_esum;
    logic [31:0]       r_smooth, n_smooth;
    logic [16:0]       r_x, n_x;
    logic [16:0]       r_x2, n_x2;
    logic [1:0]        r_quad, n_quad;
    logic [3:0][15:0]  r_sin, n_sin;
    logic [atps_pkg::MUL_P_W-1:0] r_hold, n_hold;
    logic [atps_pkg::MUL_P_W-1:0] r_lo, n_lo;
    logic [31:0]       r_speed, n_speed;
    logic              r_ovalid, n_ovalid;
    logic [31:0]       r_ofilt, n_ofilt;
    logic [31:0]       r_oraw, n_oraw;
    logic [15:0]       r_oang, n_oang;

    logic signed [atps_pkg::MUL_A_W-1:0] w_mul_a;
    logic signed [atps_pkg::MUL_B_W-1:0] w_mul_b;
    logic signed [atps_pkg::MUL_P_W-1:0] w_prod_s;
    logic [atps_pkg::MUL_P_W-1:0]        w_prod;

    // sine front end
    logic [1:0]  w_ld_idx;
    logic [31:0] w_phase, w_p;
    logic [16:0] w_xraw, w_x;
    logic [1:0]  w_quad;
    logic [16:0] w_ph, w_t1, w_t2;
    logic [15:0] w_y, w_sin;
    logic [14:0] w_ysat;

    // loop arithmetic
    logic [33:0] w_ediff;
    logic [18:0] w_esh;
    logic [15:0] w_err;
    logic [32:0] w_sumw;
    logic [31:0] w_sum;
    logic [65:0] w_full, w_spdw;
    logic [31:0] w_speed;
    logic [32:0] w_fdiff;
    logic [31:0] w_smooth_new;
    logic        w_slot_free;
    logic        w_in_ready;

    atps_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    atps_mul u_mul (
        .i_clk (i_clk),
        .i_a   (w_mul_a),
        .i_b   (w_mul_b),
        .o_p   (w_prod_s)
    );

    assign w_prod = w_prod_s;

    // phase for the next sine: measured, measured + 90deg, tracked, tracked + 90deg
    assign w_ld_idx = (r_state == atps_pkg::ST_SIN4) ? r_idx + 2'd1 : r_idx;

    always_comb begin
        case (w_ld_idx)
            2'd0:    w_phase = {r_angle, 16'd0};
            2'd1:    w_phase = {r_angle, 16'd0} + atps_pkg::QUARTER_TURN;
            2'd2:    w_phase = r_track;
            default: w_phase = r_track + atps_pkg::QUARTER_TURN;
        endcase
    end

    assign w_p    = w_phase & atps_pkg::PHASE_KEEP;
    assign w_quad = w_p[31:30];
    assign w_xraw = {1'b0, w_p[29:14]};
    assign w_x    = w_p[30] ? 17'd65536 - w_xraw : w_xraw;

    assign w_ph   = w_prod[32:16];
    assign w_t1   = atps_pkg::SIN_B - w_ph;
    assign w_t2   = atps_pkg::SIN_A - w_ph;
    assign w_y    = w_prod[32:17];
    assign w_ysat = w_y[15] ? 15'h7FFF : w_y[14:0];
    assign w_sin  = r_quad[1] ? 16'd0 - {1'b0, w_ysat} : {1'b0, w_ysat};

    // phase error, floor shift by 15 then clamp to Q1.15
    assign w_ediff = {r_hold[32], r_hold[32:0]} - {w_prod[32], w_prod[32:0]};
    assign w_esh   = w_ediff[33:15];
    assign w_err   = ((&w_esh[18:15]) || !(|w_esh[18:15])) ? w_esh[15:0] :
                     (w_esh[18] ? 16'h8000 : 16'h7FFF);

    assign w_sumw = {r_esum[31], r_esum} + {{17{w_err[15]}}, w_err};
    assign w_sum  = (w_sumw[32] == w_sumw[31]) ? w_sumw[31:0] :
                    (w_sumw[32] ? 32'h8000_0000 : 32'h7FFF_FFFF);

    // 32x32 product rebuilt from two 16-bit partials (high one in the multiplier)
    assign w_full = ({{14{w_prod[51]}}, w_prod} << 16) + {{14{r_lo[51]}}, r_lo};

    assign w_spdw  = {{13{r_hold[51]}}, r_hold, 1'b0} +
                     {{23{w_full[65]}}, w_full[65:23]};
    assign w_speed = ((&w_spdw[65:31]) || !(|w_spdw[65:31])) ? w_spdw[31:0] :
                     (w_spdw[65] ? 32'h8000_0000 : 32'h7FFF_FFFF);

    assign w_fdiff      = {r_speed[31], r_speed} - {r_smooth[31], r_smooth};
    assign w_smooth_new = r_smooth + w_prod[47:16];

    assign w_slot_free = !r_ovalid || o_out.ready;

    always_comb begin
        n_state  = r_state;
        n_idx    = r_idx;
        n_angle  = r_angle;
        n_track  = r_track;
        n_esum   = r_esum;
        n_smooth = r_smooth;
        n_x      = r_x;
        n_x2     = r_x2;
        n_quad   = r_quad;
        n_sin    = r_sin;
        n_hold   = r_hold;
        n_lo     = r_lo;
        n_speed  = r_speed;
        n_ovalid = r_ovalid && !o_out.ready;
        n_ofilt  = r_ofilt;
        n_oraw   = r_oraw;
        n_oang   = r_oang;
        w_mul_a  = '0;
        w_mul_b  = '0;
        w_in_ready = 1'b0;

        case (r_state)
            atps_pkg::ST_IDLE: begin
                w_in_ready = 1'b1;
                if (i_in.valid) begin
                    n_angle = i_in.angle_in;
                    n_idx   = 2'd0;
                    n_state = atps_pkg::ST_LOAD;
                end
            end
            atps_pkg::ST_LOAD: begin
                n_x     = w_x;
                n_quad  = w_quad;
                w_mul_a = {17'd0, w_x};
                w_mul_b = {1'b0, w_x};
                n_state = atps_pkg::ST_SIN1;
            end
            atps_pkg::ST_SIN1: begin
                n_x2    = w_ph;
                w_mul_a = {17'd0, w_ph};
                w_mul_b = atps_pkg::SIN_C;
                n_state = atps_pkg::ST_SIN2;
            end
            atps_pkg::ST_SIN2: begin
                w_mul_a = {17'd0, r_x2};
                w_mul_b = {1'b0, w_t1};
                n_state = atps_pkg::ST_SIN3;
            end
            atps_pkg::ST_SIN3: begin
                w_mul_a = {17'd0, r_x};
                w_mul_b = {1'b0, w_t2};
                n_state = atps_pkg::ST_SIN4;
            end
            atps_pkg::ST_SIN4: begin
                n_sin[r_idx] = w_sin;
                if (r_idx == 2'd3) begin
                    n_state = atps_pkg::ST_ERR0;
                end else begin
                    // start the next sine in the same cycle
                    n_idx   = r_idx + 2'd1;
                    n_x     = w_x;
                    n_quad  = w_quad;
                    w_mul_a = {17'd0, w_x};
                    w_mul_b = {1'b0, w_x};
                    n_state = atps_pkg::ST_SIN1;
                end
            end
            atps_pkg::ST_ERR0: begin
                w_mul_a = {{18{r_sin[0][15]}}, r_sin[0]};
                w_mul_b = {{2{r_sin[3][15]}}, r_sin[3]};
                n_state = atps_pkg::ST_ERR1;
            end
            atps_pkg::ST_ERR1: begin
                n_hold  = w_prod;
                w_mul_a = {{18{r_sin[1][15]}}, r_sin[1]};
                w_mul_b = {{2{r_sin[2][15]}}, r_sin[2]};
                n_state = atps_pkg::ST_ERR2;
            end
            atps_pkg::ST_ERR2: begin
                n_esum  = w_sum;
                w_mul_a = {{18{w_err[15]}}, w_err};
                w_mul_b = {2'b00, w_cfg.prop_gain};
                n_state = atps_pkg::ST_SPD0;
            end
            atps_pkg::ST_SPD0: begin
                n_hold  = w_prod;
                w_mul_a = {{2{r_esum[31]}}, r_esum};
                w_mul_b = {2'b00, w_cfg.integ_gain[15:0]};
                n_state = atps_pkg::ST_SPD1;
            end
            atps_pkg::ST_SPD1: begin
                n_lo    = w_prod;
                w_mul_a = {{2{r_esum[31]}}, r_esum};
                w_mul_b = {2'b00, w_cfg.integ_gain[31:16]};
                n_state = atps_pkg::ST_SPD2;
            end
            atps_pkg::ST_SPD2: begin
                n_speed = w_speed;
                w_mul_a = {{2{w_speed[31]}}, w_speed};
                w_mul_b = {2'b00, w_cfg.step_gain[15:0]};
                n_state = atps_pkg::ST_ADV0;
            end
            atps_pkg::ST_ADV0: begin
                n_lo    = w_prod;
                w_mul_a = {{2{r_speed[31]}}, r_speed};
                w_mul_b = {2'b00, w_cfg.step_gain[31:16]};
                n_state = atps_pkg::ST_ADV1;
            end
            atps_pkg::ST_ADV1: begin
                n_track = r_track + w_full[47:16];
                w_mul_a = {w_fdiff[32], w_fdiff};
                w_mul_b = {2'b00, w_cfg.filter_alpha};
                n_state = atps_pkg::ST_FILT;
            end
            atps_pkg::ST_FILT: begin
                // operands held so the product stays put while the output stalls
                w_mul_a = {w_fdiff[32], w_fdiff};
                w_mul_b = {2'b00, w_cfg.filter_alpha};
                if (w_slot_free) begin
                    n_smooth = w_smooth_new;
                    n_ovalid = 1'b1;
                    n_ofilt  = w_smooth_new;
                    n_oraw   = r_speed;
                    n_oang   = r_track[31:16];
                    n_state  = atps_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = atps_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= atps_pkg::ST_IDLE;
            r_idx    <= 2'd0;
            r_track  <= '0;
            r_esum   <= '0;
            r_smooth <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_idx    <= n_idx;
            r_track  <= n_track;
            r_esum   <= n_esum;
            r_smooth <= n_smooth;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_angle <= n_angle;
        r_x     <= n_x;
        r_x2    <= n_x2;
        r_quad  <= n_quad;
        r_sin   <= n_sin;
        r_hold  <= n_hold;
        r_lo    <= n_lo;
        r_speed <= n_speed;
        r_ofilt <= n_ofilt;
        r_oraw  <= n_oraw;
        r_oang  <= n_oang;
    end

    assign i_in.ready           = w_in_ready;
    assign o_out.valid          = r_ovalid;
    assign o_out.speed_filtered = r_ofilt;
    assign o_out.speed_raw      = r_oraw;
    assign o_out.tracked_angle  = r_oang;

    `AST_ON_RST(a_load_first_sine, i_clk, i_rst_n, (r_state == atps_pkg::ST_LOAD) |-> (r_idx == 2'd0))
    `AST_ON_RST(a_accept_starts, i_clk, i_rst_n, (i_in.valid && i_in.ready) |=> (r_state == atps_pkg::ST_LOAD))
    `AST_ON_RST(a_result_from_filter, i_clk, i_rst_n, $rose(r_ovalid) |-> ($past(r_state) == atps_pkg::ST_FILT))
    `AST_ALWAYS(a_reset_to_idle, i_clk, !i_rst_n |=> (r_state == atps_pkg::ST_IDLE))

endmodule

// ----- tb/angle_tracking_pll_speed_test.sv -----
// ----------------------------------------------------------------------------
// angle_tracking_pll_speed_test
// Self-checking bench for the angle tracking PLL speed estimator. A bit-exact
// predictor of the loop (polynomial sines, phase error, saturating error sum,
// PI speed, phase advance, speed low-pass) computes each result beat from the
// accepted angle beats. Gains go through the APB port and are read back.
// Stimulus covers register defaults, corner angles, gain extremes, an error-sum
// windup run, randomized rotating-angle sequences with noise and random angle
// jumps, under bursty input traffic and a stalling result sink.
// ----------------------------------------------------------------------------
module angle_tracking_pll_speed_test;
    import atps_pkg::*;

    localparam int     CLK_PERIOD     = 12;
    localparam longint TIMEOUT_CYCLES = 8_000_000;
    localparam int     SUM_FILL_BEATS = 400;
    localparam int     RANDOM_PHASES  = 8;
    localparam int     PHASE_BEATS    = 200;

    // sine evaluation of the predictor
    localparam int               SINE_BITS    = 16;
    localparam logic [31:0]      SINE_KEEP    = ~((32'd1 << (32 - SINE_BITS)) - 32'd1);
    localparam logic [31:0]      TURN_QUARTER = 32'h4000_0000;
    localparam longint unsigned  POLY_A       = 102944;
    localparam longint unsigned  POLY_B       = 42047;
    localparam longint unsigned  POLY_C       = 4640;
    localparam longint           S32_MIN      = -64'sd2147483648;
    localparam longint           S32_MAX      = 64'sd2147483647;

    localparam t_cfg GAINS_AT_RESET = '{16'd1200, 32'd301989888, 32'd34178, 16'd328};
    localparam t_cfg GAINS_ALL_MAX  = '{16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF};
    localparam t_cfg GAINS_ALL_ZERO = '{16'd0, 32'd0, 32'd0, 16'd0};

    typedef struct {
        logic signed [31:0] filtered;
        logic signed [31:0] raw;
        logic        [15:0] angle;
    } t_speed_result;

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [APB_AW-1:0]   paddr;
    logic [APB_DW-1:0]   pwdata;
    logic [APB_DW-1:0]   prdata;
    logic                pready;

    atps_in_if  in_ch();
    atps_out_if out_ch();

    angle_tracking_pll_speed u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // predictor state and gains
    t_cfg          gains;
    logic [31:0]   loop_phase;
    int            err_accum;
    int            speed_lp;
    t_speed_result pending_results[$];

    int errors_found  = 0;
    int beats_sent    = 0;
    int results_seen  = 0;
    int reg_writes    = 0;
    int gain_sets     = 0;
    int burst_left    = 0;
    bit full_rate     = 1'b0;

    function automatic longint saturate(longint v, longint lo, longint hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    // Q1.15 sine of a Q0.32 turn, odd-quadrant fold and sign from the upper half
    function automatic longint quarter_sine(logic [31:0] phase);
        logic [31:0]     p;
        longint unsigned x, x2, t, y;
        p = phase & SINE_KEEP;
        x = 64'(p[29:14]);
        if (p[30]) x = 65536 - x;
        x2 = (x * x) >> 16;
        t  = (POLY_C * x2) >> 16;
        t  = POLY_B - t;
        t  = (t * x2) >> 16;
        t  = POLY_A - t;
        y  = ((t * x) >> 16) >> 1;
        if (y > 32767) y = 32767;
        return p[31] ? -longint'(y) : longint'(y);
    endfunction

    function automatic t_speed_result track_pll_update(logic [15:0] angle);
        logic [31:0]   meas;
        longint        s_m, c_m, s_t, c_t, err, acc, spd, adv, lp;
        longint        kp, ki, ks, ka;
        t_speed_result r;
        meas = {angle, 16'h0000};
        s_m  = quarter_sine(meas);
        c_m  = quarter_sine(meas + TURN_QUARTER);
        s_t  = quarter_sine(loop_phase);
        c_t  = quarter_sine(loop_phase + TURN_QUARTER);
        kp   = longint'(gains.prop_gain);
        ki   = longint'(gains.integ_gain);
        ks   = longint'(gains.step_gain);
        ka   = longint'(gains.filter_alpha);

        err = saturate((s_m * c_t - c_m * s_t) >>> 15, -32768, 32767);
        acc = saturate(longint'(err_accum) + err, S32_MIN, S32_MAX);
        err_accum = int'(acc);

        spd = saturate(kp * err * 2 + ((ki * acc) >>> 23), S32_MIN, S32_MAX);
        adv = (spd * ks) >>> 16;
        loop_phase = loop_phase + adv[31:0];

        lp = saturate(longint'(speed_lp) + ((ka * (spd - speed_lp)) >>> 16),
                      S32_MIN, S32_MAX);
        speed_lp = int'(lp);

        r.filtered = speed_lp;
        r.raw      = spd[31:0];
        r.angle    = loop_phase[31:16];
        return r;
    endfunction

    function automatic logic [31:0] gain_value(t_reg_idx idx);
        case (idx)
            REG_PROP_GAIN:    return {16'h0000, gains.prop_gain};
            REG_INTEG_GAIN:   return gains.integ_gain;
            REG_STEP_GAIN:    return gains.step_gain;
            default:          return {16'h0000, gains.filter_alpha};
        endcase
    endfunction

    function automatic logic [31:0] pick_gain(logic [31:0] full_scale, logic [31:0] nominal);
        case ($urandom_range(0, 5))
            0:       return 32'd0;
            1:       return full_scale;
            2:       return nominal;
            3:       return $urandom & full_scale;
            default: return ($urandom_range(1, 8) * nominal) >> 2;
        endcase
    endfunction

    task automatic report_error(string msg);
        errors_found++;
        if (errors_found <= 30)
            $display("ERROR @%0t: %s", $time, msg);
    endtask

    // one angle beat; between bursts the valid line drops for a random gap
    task automatic send_angle(logic [15:0] angle);
        @(negedge i_clk);
        in_ch.valid    = 1'b1;
        in_ch.angle_in = angle;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        pending_results.push_back(track_pll_update(angle));
        beats_sent++;
        if (!full_rate) begin
            if (burst_left > 0) burst_left--;
            if (burst_left == 0) begin
                @(negedge i_clk);
                in_ch.valid = 1'b0;
                repeat ($urandom_range(1, 16)) @(negedge i_clk);
                burst_left = $urandom_range(1, 48);
            end
        end
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        in_ch.valid = 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(t_reg_idx idx, logic [31:0] value);
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = value;
        @(negedge i_clk);
        penable = 1'b1;
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        case (idx)
            REG_PROP_GAIN:    gains.prop_gain    = value[15:0];
            REG_INTEG_GAIN:   gains.integ_gain   = value;
            REG_STEP_GAIN:    gains.step_gain    = value;
            REG_FILTER_ALPHA: gains.filter_alpha = value[15:0];
        endcase
        reg_writes++;
    endtask

    task automatic read_reg(t_reg_idx idx, output logic [31:0] value);
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = {idx, 2'b00};
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        value = prdata;
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    task automatic verify_registers();
        t_reg_idx    idx;
        logic [31:0] got;
        for (int i = 0; i < 4; i++) begin
            idx = t_reg_idx'(i);
            read_reg(idx, got);
            if (got !== gain_value(idx))
                report_error($sformatf("register %s read 0x%08h, expected 0x%08h",
                                       idx.name(), got, gain_value(idx)));
        end
    endtask

    // only call with the loop idle
    task automatic program_gains(t_cfg next_gains);
        write_reg(REG_PROP_GAIN,    {16'h0000, next_gains.prop_gain});
        write_reg(REG_INTEG_GAIN,   next_gains.integ_gain);
        write_reg(REG_STEP_GAIN,    next_gains.step_gain);
        write_reg(REG_FILTER_ALPHA, {16'h0000, next_gains.filter_alpha});
        gain_sets++;
        verify_registers();
    endtask

    task automatic test_register_defaults();
        verify_registers();
    endtask

    task automatic test_directed_angles();
        logic [15:0] corners [12] = '{16'h0000, 16'hFFFF, 16'h4000, 16'h8000, 16'hC000,
                                      16'h0001, 16'h7FFF, 16'h8001, 16'h5555, 16'hAAAA,
                                      16'h3FFF, 16'hC001};
        foreach (corners[i]) send_angle(corners[i]);
        drain_results();
    endtask

    // full-scale gains drive the speed into both rails; all-zero gains freeze it
    task automatic test_gain_extremes();
        program_gains(GAINS_ALL_MAX);
        send_angle(16'h4000);
        send_angle(16'h4000);
        send_angle(16'hC000);
        send_angle(16'h0000);
        send_angle(16'hFFFF);
        send_angle(16'h8000);
        drain_results();
        program_gains(GAINS_ALL_ZERO);
        send_angle(16'h4000);
        send_angle(16'hC000);
        send_angle(16'h3039);
        send_angle(16'h0000);
        drain_results();
    endtask

    // step gain zero holds the tracked phase, so a fixed quarter-turn lead
    // keeps the error near full scale and winds the sum up, then reverses
    task automatic test_error_sum_windup();
        logic [15:0] held;
        program_gains('{16'd1, 32'h0100_0000, 32'd0, 16'hFFFF});
        held = loop_phase[31:16];
        full_rate = 1'b1;
        repeat (SUM_FILL_BEATS) send_angle(held + 16'h4000);
        repeat (8) send_angle(held - 16'h4000);
        full_rate = 1'b0;
        drain_results();
    endtask

    task automatic test_random_tracking();
        t_cfg        next_gains;
        int          sent;
        int          seq_len;
        int          vel;
        int          noise;
        int unsigned pos;
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            drain_results();
            if (ph == 0) begin
                next_gains = GAINS_AT_RESET;
            end else begin
                next_gains.prop_gain    = 16'(pick_gain(32'hFFFF, 32'd1200));
                next_gains.integ_gain   = pick_gain(32'hFFFF_FFFF, 32'd301989888);
                next_gains.step_gain    = pick_gain(32'hFFFF_FFFF, 32'd34178);
                next_gains.filter_alpha = 16'(pick_gain(32'hFFFF, 32'd328));
            end
            program_gains(next_gains);
            sent = 0;
            while (sent < PHASE_BEATS) begin
                if ($urandom_range(0, 4) != 0) begin
                    // rotating rotor: constant step plus jitter
                    seq_len = $urandom_range(8, 64);
                    pos     = $urandom;
                    vel     = ($urandom_range(0, 7) == 0) ? int'($urandom)
                                                          : int'($urandom_range(0, 4000)) - 2000;
                    noise   = $urandom_range(0, 64);
                    repeat (seq_len) begin
                        pos = pos + vel + $urandom_range(0, 2 * noise) - noise;
                        send_angle(pos[15:0]);
                        sent++;
                    end
                end else begin
                    repeat ($urandom_range(1, 16)) begin
                        send_angle(16'($urandom_range(0, 65535)));
                        sent++;
                    end
                end
            end
        end
    endtask

    // result sink: always ready, random, mostly ready, or long stalls
    initial begin : pace_result_ready
        int mode;
        int run;
        out_ch.ready = 1'b0;
        forever begin
            mode = $urandom_range(0, 3);
            run  = $urandom_range(20, 300);
            repeat (run) begin
                @(negedge i_clk);
                if (full_rate) begin
                    out_ch.ready = 1'b1;
                end else begin
                    case (mode)
                        0:       out_ch.ready = 1'b1;
                        1:       out_ch.ready = 1'($urandom_range(0, 1));
                        2:       out_ch.ready = ($urandom_range(0, 7) != 0);
                        default: out_ch.ready = ($urandom_range(0, 9) == 0);
                    endcase
                end
            end
        end
    end

    always @(posedge i_clk) begin : check_results
        t_speed_result want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                report_error("result beat with no sample outstanding");
            end else begin
                want = pending_results.pop_front();
                if (out_ch.speed_filtered !== want.filtered)
                    report_error($sformatf("speed_filtered: expected %0d, got %0d",
                                           want.filtered, out_ch.speed_filtered));
                if (out_ch.speed_raw !== want.raw)
                    report_error($sformatf("speed_raw: expected %0d, got %0d",
                                           want.raw, out_ch.speed_raw));
                if (out_ch.tracked_angle !== want.angle)
                    report_error($sformatf("tracked_angle: expected %0d, got %0d",
                                           want.angle, out_ch.tracked_angle));
            end
        end
    end

    initial begin
        i_rst_n        = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        in_ch.valid    = 1'b0;
        in_ch.angle_in = 16'h0000;
        gains          = GAINS_AT_RESET;
        loop_phase     = 32'd0;
        err_accum      = 0;
        speed_lp       = 0;
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_register_defaults();
        test_directed_angles();
        test_gain_extremes();
        test_error_sum_windup();
        test_random_tracking();

        drain_results();
        repeat (30) @(posedge i_clk);
        $display("Covered %0d angle beats and %0d result beats, %0d winding up the sum,",
                 beats_sent, results_seen, SUM_FILL_BEATS);
        $display("over %0d gain sets (%0d register writes) incl. defaults and both extremes.",
                 gain_sets, reg_writes);
        if (errors_found == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin : watchdog
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("Timeout with %0d results outstanding", pending_results.size());
        $display("Mismatches found");
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+src
src/atps_pkg.sv
src/atps_if.sv
src/atps_mul.sv
src/atps_cfg.sv
src/angle_tracking_pll_speed.sv
tb/angle_tracking_pll_speed_test.sv
